FILE: sv/ndr_pkg.sv
// ----------------------------------------------------------------------------
// ndr_pkg
// Shared constants for the noise-shaped dither requantizer.
// ----------------------------------------------------------------------------
package ndr_pkg;

   // Width of the source sample word.
   localparam int SRC_W = 32;

   // Default output sample width.
   localparam int OUTPUT_BITS_DEFAULT = 16;

   // Source format register codes.
   localparam logic FMT_24 = 1'b0;
   localparam logic FMT_32 = 1'b1;

   // Pseudo-random generator: r' = r * LCG_MUL + LCG_ADD, modulo 2^32.
   localparam logic [31:0] LCG_MUL = 32'h0019_660D;
   localparam logic [31:0] LCG_ADD = 32'h3C6E_F35F;

endpackage

FILE: sv/ndr_req_if.sv
// ----------------------------------------------------------------------------
// ndr_req_if
// Input channel: one signed source sample and its last flag per item.
// ----------------------------------------------------------------------------
interface ndr_req_if;
   logic                             valid;
   logic                             ready;
   logic signed [ndr_pkg::SRC_W-1:0] sample;
   logic                             last;

   modport source (output valid, output sample, output last, input ready);
   modport sink (input valid, input sample, input last, output ready);
endinterface

FILE: sv/ndr_rsp_if.sv
// ----------------------------------------------------------------------------
// ndr_rsp_if
// Result channel: one requantized sample and its last flag per item.
// ----------------------------------------------------------------------------
interface ndr_rsp_if #(
   parameter int OUTPUT_BITS = ndr_pkg::OUTPUT_BITS_DEFAULT
);
   logic                          valid;
   logic                          ready;
   logic signed [OUTPUT_BITS-1:0] dithered_sample;
   logic                          last_res;

   modport source (output valid, output dithered_sample, output last_res, input ready);
   modport sink (input valid, input dithered_sample, input last_res, output ready);
endinterface

FILE: sv/noise_shaped_dither_requantizer_unit.sv
// An accepted item passes the input register, then the result register.
// Throughput: one item per cycle while the result is taken or the result register is empty.
// The next pseudo-random word is precomputed one item ahead, keeping the
// LCG multiplier out of the sample path.
// Reset (synchronous, active high) clears the format register, the error
// terms and both valid flags, and reseeds the random state.
// ----------------------------------------------------------------------------
// noise_shaped_dither_requantizer_unit
// Requantizes signed 24- or 32-bit samples to OUTPUT_BITS with noise-shaped
// triangular dither.
// ----------------------------------------------------------------------------
module noise_shaped_dither_requantizer_unit #(
   parameter int OUTPUT_BITS = ndr_pkg::OUTPUT_BITS_DEFAULT
) (
   input  logic        clock,
   input  logic        reset,
   input  logic        csr_wen,
   input  logic        csr_wdata,
   ndr_req_if.sink     req_ch,
   ndr_rsp_if.source   rsp_ch
);

   localparam int ERR_W = ndr_pkg::SRC_W - OUTPUT_BITS + 3;

   logic                             fmt_ff;
   logic                             s1_valid_ff;
   logic signed [ndr_pkg::SRC_W-1:0] s1_sample_ff;
   logic                             s1_last_ff;
   logic                             rsp_valid_ff;
   logic signed [OUTPUT_BITS-1:0]    rsp_data_ff;
   logic                             rsp_last_ff;
   logic signed [ERR_W-1:0]          err_now_ff;
   logic signed [ERR_W-1:0]          err_half_prev_ff;
   logic signed [ERR_W-1:0]          err_half_older_ff;
   logic [31:0]                      rand_cur_ff;
   logic [31:0]                      rand_nxt_ff;
   logic [31:0]                      rand_nxt_in;

   logic                             advance;
   logic                             s1_fire;
   logic                             req_fire;
   logic signed [OUTPUT_BITS-1:0]    result;
   logic signed [ERR_W-1:0]          err_now_in;
   logic signed [ERR_W-1:0]          err_half_in;

   // The result register frees when it is empty or its item is taken.
   assign advance      = !rsp_valid_ff || rsp_ch.ready;
   assign s1_fire      = s1_valid_ff && advance;
   assign req_ch.ready = !s1_valid_ff || advance;
   assign req_fire     = req_ch.valid && req_ch.ready;

   assign rsp_ch.valid           = rsp_valid_ff;
   assign rsp_ch.dithered_sample = rsp_data_ff;
   assign rsp_ch.last_res        = rsp_last_ff;

   assign rand_nxt_in = 32'(rand_nxt_ff * ndr_pkg::LCG_MUL) + ndr_pkg::LCG_ADD;

   ndr_shaper #(
      .OUTPUT_BITS (OUTPUT_BITS),
      .ERR_W       (ERR_W)
   ) u_shaper (
      .fmt            (fmt_ff),
      .sample         (s1_sample_ff),
      .err_now        (err_now_ff),
      .err_half_prev  (err_half_prev_ff),
      .err_half_older (err_half_older_ff),
      .rand_cur       (rand_cur_ff),
      .rand_nxt       (rand_nxt_ff),
      .result         (result),
      .err_now_new    (err_now_in),
      .err_half_new   (err_half_in)
   );

   always_ff @(posedge clock) begin
      if (reset) begin
         fmt_ff            <= ndr_pkg::FMT_24;
         s1_valid_ff       <= 1'b0;
         rsp_valid_ff      <= 1'b0;
         err_now_ff        <= '0;
         err_half_prev_ff  <= '0;
         err_half_older_ff <= '0;
         rand_cur_ff       <= '0;
         rand_nxt_ff       <= ndr_pkg::LCG_ADD;
      end else begin
         if (csr_wen) begin
            fmt_ff <= csr_wdata;
         end
         if (req_ch.ready) begin
            s1_valid_ff <= req_ch.valid;
         end
         if (advance) begin
            rsp_valid_ff <= s1_valid_ff;
         end
         if (s1_fire) begin
            err_now_ff        <= err_now_in;
            err_half_prev_ff  <= err_half_in;
            err_half_older_ff <= err_half_prev_ff;
            rand_cur_ff       <= rand_nxt_ff;
            rand_nxt_ff       <= rand_nxt_in;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (req_fire) begin
         s1_sample_ff <= req_ch.sample;
         s1_last_ff   <= req_ch.last;
      end
      if (s1_fire) begin
         rsp_data_ff <= result;
         rsp_last_ff <= s1_last_ff;
      end
   end

endmodule

FILE: sv/ndr_shaper.sv
// ----------------------------------------------------------------------------
// ndr_shaper
// Combinational datapath: error feedback, rounding, TPDF dither, clipping,
// requantization and the new error terms for one sample.
// ----------------------------------------------------------------------------
module ndr_shaper #(
   parameter int OUTPUT_BITS = ndr_pkg::OUTPUT_BITS_DEFAULT,
   parameter int ERR_W       = ndr_pkg::SRC_W - OUTPUT_BITS + 3
) (
   input  logic                             fmt,
   input  logic signed [ndr_pkg::SRC_W-1:0] sample,
   input  logic signed [ERR_W-1:0]          err_now,
   input  logic signed [ERR_W-1:0]          err_half_prev,
   input  logic signed [ERR_W-1:0]          err_half_older,
   input  logic [31:0]                      rand_cur,
   input  logic [31:0]                      rand_nxt,
   output logic signed [OUTPUT_BITS-1:0]    result,
   output logic signed [ERR_W-1:0]          err_now_new,
   output logic signed [ERR_W-1:0]          err_half_new
);

   localparam int SUM_W   = ndr_pkg::SRC_W + 3;
   localparam int SCALE24 = (OUTPUT_BITS < 24) ? (24 - OUTPUT_BITS) : 0;
   localparam int SCALE32 = ndr_pkg::SRC_W - OUTPUT_BITS;

   localparam logic [31:0] MASK24  = 32'((64'd1 << SCALE24) - 64'd1);
   localparam logic [31:0] MASK32  = 32'((64'd1 << SCALE32) - 64'd1);
   localparam logic [31:0] ROUND24 = 32'((64'(MASK24) + 64'd1) >> 1);
   localparam logic [31:0] ROUND32 = 32'((64'(MASK32) + 64'd1) >> 1);

   localparam logic signed [SUM_W-1:0] HI24 = SUM_W'((64'sd1 <<< 23) - 64'sd1);
   localparam logic signed [SUM_W-1:0] LO24 = SUM_W'(-(64'sd1 <<< 23));
   localparam logic signed [SUM_W-1:0] HI32 = SUM_W'((64'sd1 <<< 31) - 64'sd1);
   localparam logic signed [SUM_W-1:0] LO32 = SUM_W'(-(64'sd1 <<< 31));

   logic [31:0]             mask;
   logic [31:0]             round;
   logic signed [SUM_W-1:0] hi;
   logic signed [SUM_W-1:0] lo;
   logic signed [SUM_W-1:0] shaped;
   logic signed [SUM_W-1:0] dither;
   logic signed [SUM_W-1:0] rounded;
   logic signed [SUM_W-1:0] out_clip;
   logic signed [SUM_W-1:0] shaped_clip;
   logic signed [SUM_W-1:0] out_floor;
   logic signed [SUM_W-1:0] err_full;
   logic signed [ERR_W-1:0] err_sign;

   always_comb begin
      if (fmt == ndr_pkg::FMT_32) begin
         mask  = MASK32;
         round = ROUND32;
         hi    = HI32;
         lo    = LO32;
      end else begin
         mask  = MASK24;
         round = ROUND24;
         hi    = HI24;
         lo    = LO24;
      end
   end

   always_comb begin
      shaped = SUM_W'(sample) + SUM_W'(err_now) - SUM_W'(err_half_prev)
             + SUM_W'(err_half_older);
      // Triangular dither: new masked word minus previous masked word.
      dither = SUM_W'($signed({1'b0, rand_nxt & mask}))
             - SUM_W'($signed({1'b0, rand_cur & mask}));
      rounded = shaped + SUM_W'($signed({1'b0, round})) + dither;

      out_clip    = rounded;
      shaped_clip = shaped;
      if (rounded > hi) begin
         out_clip = hi;
         if (shaped > hi) begin
            shaped_clip = hi;
         end
      end else if (rounded < lo) begin
         out_clip = lo;
         if (shaped < lo) begin
            shaped_clip = lo;
         end
      end

      out_floor = out_clip & ~SUM_W'($signed({1'b0, mask}));
      err_full  = shaped_clip - out_floor;
   end

   assign err_now_new = err_full[ERR_W-1:0];

   // Halve toward zero: add one to negative values before the arithmetic shift.
   assign err_sign     = $signed({{(ERR_W-1){1'b0}}, err_now[ERR_W-1]});
   assign err_half_new = (err_now + err_sign) >>> 1;

   always_comb begin
      if (fmt == ndr_pkg::FMT_32) begin
         result = out_floor[SCALE32 +: OUTPUT_BITS];
      end else begin
         result = out_floor[SCALE24 +: OUTPUT_BITS];
      end
   end

endmodule
